### hw/rtl/sfr_pkg.sv
// Shared constants and helpers for the S.BUS frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned FRAME_LEN   = 25;
  localparam int unsigned NUM_CHANS   = 16;
  localparam int unsigned PAYLOAD_LEN = 22;
  localparam int unsigned RAW_W       = 11;
  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned COUNT_W     = 16;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE_0 = 8'h00;
  localparam logic [7:0] END_BYTE_1 = 8'h04;
  localparam logic [7:0] END_BYTE_2 = 8'h14;
  localparam logic [7:0] END_BYTE_3 = 8'h24;
  localparam logic [7:0] END_BYTE_4 = 8'h34;

  // Fill level at which the next word completes a full window.
  localparam logic [FILL_W-1:0] FILL_ARMED = 5'd24;

  localparam logic [14:0] PULSE_OFFSET = 15'd7040;

  function automatic logic end_byte_ok(input logic [7:0] b);
    return (b == END_BYTE_0) || (b == END_BYTE_1) || (b == END_BYTE_2) ||
           (b == END_BYTE_3) || (b == END_BYTE_4);
  endfunction

  // (5*raw + 7040) >> 3, exact for any 11-bit raw value.
  function automatic logic [PULSE_W-1:0] pulse_of(input logic [RAW_W-1:0] raw);
    logic [14:0] sum;
    sum = {2'b00, raw, 2'b00} + {4'b0000, raw} + PULSE_OFFSET;
    return sum[14:3];
  endfunction

endpackage

### hw/rtl/sfr_rx_if.sv
// Byte input channel of the S.BUS frame receiver.
`timescale 1ns / 1ps

interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### hw/rtl/sfr_chan_if.sv
// Channel result channel of the S.BUS frame receiver.
`timescale 1ns / 1ps

interface sfr_chan_if;
  logic                            valid;
  logic                            ready;
  logic [sfr_pkg::IDX_W-1:0]       chan_index;
  logic [sfr_pkg::RAW_W-1:0]       chan_raw;
  logic [sfr_pkg::PULSE_W-1:0]     pulse_us;
  logic                            last_chan;
  logic [sfr_pkg::COUNT_W-1:0]     frames_seen;

  modport source (output valid, output chan_index, output chan_raw, output pulse_us,
                  output last_chan, output frames_seen, input ready);
  modport sink   (input valid, input chan_index, input chan_raw, input pulse_us,
                  input last_chan, input frames_seen, output ready);
endinterface

### hw/rtl/sfr_cell.sv
// One storage cell of a shift chain: takes its neighbor's value when enabled.
`timescale 1ns / 1ps

module sfr_cell #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

### hw/rtl/sbus_frame_receiver.sv
// Top level of the S.BUS frame receiver: byte window, frame check, channel burst.
`timescale 1ns / 1ps

// Usage:
//   rx   : one serial word (rx_byte) per handshake. Words shift into a row of
//          25 byte cells; the newest sits at the tail, the oldest at the head.
//   chan : sixteen channel words per accepted frame, in channel order, each
//          with raw value, pulse width in microseconds, last-channel mark and
//          the frame count including this frame.
// Throughput: one rx word per cycle while rx.ready is high. When the word that
//   completes a window arrives, the window is checked in that same cycle; on a
//   match the 22 payload bytes are unpacked into a row of 16 channel cells, the
//   fill count clears and a new window starts filling at once.
// Output: a match loads the channel cells and burst count; the first word is then
//   registered from cell 0, the rest one per cycle while chan.ready is high.
// Rate limit: the channel cell row holds one frame. A word that would complete
//   a window is held off (rx.ready low) while the previous burst still drains,
//   so rx stalls only while the sink still holds back the previous burst.
// Mismatch: the window slides by one word; the next word is checked again.
// Stall: chan holds its word while ready is low; rx fills until a window is armed.
// Reset: fill count, frame counter, burst count and chan.valid clear; the byte
//   cells keep stale data, which is never checked before 25 new words arrive.
module sbus_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  sfr_rx_if.sink      rx,
  sfr_chan_if.source  chan
);

  localparam int unsigned N  = sfr_pkg::FRAME_LEN;
  localparam int unsigned NC = sfr_pkg::NUM_CHANS;
  localparam int unsigned RW = sfr_pkg::RAW_W;

  // Byte window cells, index 0 is the oldest.
  logic [7:0] win_q [N];
  logic [7:0] win_d [N];

  // Channel cells, index 0 is the next channel to send.
  logic [RW-1:0] ch_q [NC];
  logic [RW-1:0] ch_d [NC];

  logic [sfr_pkg::FILL_W-1:0]  fill_count;
  logic [sfr_pkg::COUNT_W-1:0] frame_counter;
  logic [sfr_pkg::COUNT_W-1:0] burst_frames;
  logic [4:0]                  remaining;
  logic [4:0]                  sent_next;

  logic rx_fire;
  logic frame_hit;
  logic out_adv;
  logic [8*sfr_pkg::PAYLOAD_LEN-1:0] payload;

  assign rx.ready  = !((fill_count == sfr_pkg::FILL_ARMED) && (remaining != 5'd0));
  assign rx_fire   = rx.valid && rx.ready;

  // Check the window as it will stand after this word: oldest is cell 1 now,
  // the end byte is the incoming word.
  assign frame_hit = rx_fire && (fill_count == sfr_pkg::FILL_ARMED) &&
                     (win_q[1] == sfr_pkg::START_BYTE) &&
                     sfr_pkg::end_byte_ok(rx.rx_byte);

  assign out_adv = (remaining != 5'd0) && (!chan.valid || chan.ready);

  // Payload bytes 1..22 of the completed window are cells 2..23 before shift.
  always_comb begin
    for (int j = 0; j < sfr_pkg::PAYLOAD_LEN; j++) begin
      payload[8*j +: 8] = win_q[j+2];
    end
  end

  always_comb begin
    for (int i = 0; i < N - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[N-1] = rx.rx_byte;
  end

  // Load all channels on a match, else advance toward cell 0; the tail empties.
  always_comb begin
    for (int k = 0; k < NC - 1; k++) begin
      if (frame_hit) begin
        ch_d[k] = payload[RW*k +: RW];
      end else begin
        ch_d[k] = ch_q[k+1];
      end
    end
    if (frame_hit) begin
      ch_d[NC-1] = payload[RW*(NC-1) +: RW];
    end else begin
      ch_d[NC-1] = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_win
    sfr_cell #(.W(8)) u_cell (
      .clk (clk),
      .en  (rx_fire),
      .d   (win_d[i]),
      .q   (win_q[i])
    );
  end

  for (genvar k = 0; k < NC; k++) begin : g_chan
    sfr_cell #(.W(RW)) u_cell (
      .clk (clk),
      .en  (frame_hit || out_adv),
      .d   (ch_d[k]),
      .q   (ch_q[k])
    );
  end

  assign sent_next = 5'(NC) - remaining;

  // Fill count and frame counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      frame_counter <= '0;
    end else if (rx_fire) begin
      if (frame_hit) begin
        fill_count    <= '0;
        frame_counter <= frame_counter + 16'd1;
      end else if (fill_count != sfr_pkg::FILL_ARMED) begin
        fill_count <= fill_count + 5'd1;
      end
    end
  end

  // Burst count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining  <= '0;
      chan.valid <= 1'b0;
    end else begin
      if (frame_hit) begin
        remaining    <= 5'(NC);
        burst_frames <= frame_counter + 16'd1;
      end else if (out_adv) begin
        remaining <= remaining - 5'd1;
      end

      if (out_adv) begin
        chan.valid       <= 1'b1;
        chan.chan_index  <= sent_next[3:0];
        chan.chan_raw    <= ch_q[0];
        chan.pulse_us    <= sfr_pkg::pulse_of(ch_q[0]);
        chan.last_chan   <= (remaining == 5'd1);
        chan.frames_seen <= burst_frames;
      end else if (chan.ready) begin
        chan.valid <= 1'b0;
      end
    end
  end

  // Checks.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= sfr_pkg::FILL_ARMED)
    else $error("fill count beyond armed level");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    frame_hit |-> (remaining == 5'd0))
    else $error("frame accepted while burst still draining");

  a_burst_load: assert property (@(posedge clk) disable iff (rst)
    frame_hit |=> (remaining == 5'(NC)) && (fill_count == '0))
    else $error("burst not loaded after frame match");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    chan.valid |-> (chan.last_chan == (chan.chan_index == 4'(NC - 1))))
    else $error("last channel mark out of place");

endmodule
